// ===== design/cms_pkg.sv =====
// Package for the CAN message segmenter: frame constants, register indexes
// and shared types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cms_pkg;

    localparam int FRAME_BYTES   = 8;
    localparam int LANE_W        = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int CNT_W         = $clog2(FRAME_BYTES + 1);
    localparam int PAYLOAD_W     = 64;
    localparam int CFG_INDEX_W   = 8;
    localparam int SEQ_W         = 4;

    localparam logic [7:0] INFO_EXT_FLAG = 8'h80;
    localparam logic [7:0] ID_LOW_FIXED  = 8'hF0;

    localparam logic [CFG_INDEX_W-1:0] REG_ID_HIGH = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_ID_MID  = CFG_INDEX_W'(1);

    typedef logic [7:0]             t_byte;
    typedef logic [PAYLOAD_W-1:0]   t_payload;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

endpackage

`default_nettype wire

// ===== design/cms_if.sv =====
// Channel interfaces of the CAN message segmenter: input bytes, frames out
// and register writes. Depends on cms_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cms_in_if;
    import cms_pkg::*;
    logic  valid;
    logic  ready;
    t_byte data_byte;
    t_byte msg_length;

    modport source (output valid, output data_byte, output msg_length, input ready);
    modport sink   (input valid, input data_byte, input msg_length, output ready);
endinterface

interface cms_out_if;
    import cms_pkg::*;
    logic     valid;
    logic     ready;
    t_byte    frame_info;
    t_byte    id_byte_high;
    t_byte    id_byte_mid;
    t_byte    sequence_byte;
    t_byte    id_byte_low;
    t_payload payload;
    logic     last_frame;

    modport source (output valid, output frame_info, output id_byte_high,
                    output id_byte_mid, output sequence_byte, output id_byte_low,
                    output payload, output last_frame, input ready);
    modport sink   (input valid, input frame_info, input id_byte_high,
                    input id_byte_mid, input sequence_byte, input id_byte_low,
                    input payload, input last_frame, output ready);
endinterface

interface cms_cfg_if;
    import cms_pkg::*;
    logic       valid;
    logic       ready;
    t_cfg_index index;
    t_byte      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/can_message_segmenter.sv =====
// Top level of the CAN message segmenter: gathers message bytes into
// extended CAN frames of up to eight bytes. Depends on cms_pkg and cms_if.
//
// Use:
//   i_in  : one message byte per request, with the total message length
//           (1 to 255, zero taken as one) sampled on the first byte only.
//   o_out : one frame per full group of eight bytes and one for the final,
//           possibly partial, group; last_frame marks the end of a message.
//   i_cfg : register writes, index 0 id_high, index 1 id_mid; other indexes
//           are dropped. Always ready; write only while the block is idle.
// Timing: a byte is registered on acceptance, then processed; the frame it
//   completes is registered in the frame register. One byte per cycle is
//   sustained while o_out is not stalled, set by the single processing
//   stage between the input register and the frame register.
// Reset: clears both registers' valid flags, the gather state and the
//   identifier registers; no message is open afterwards.
// Stall: a held frame stops processing; the input register then fills and
//   i_in.ready falls until the frame is taken.
`timescale 1ns / 1ps
`default_nettype none

module can_message_segmenter (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cms_in_if.sink     i_in,
    cms_out_if.source  o_out,
    cms_cfg_if.sink    i_cfg
);
    import cms_pkg::*;

    logic             r_in_valid;
    t_byte            r_byte;
    t_byte            r_len;

    t_byte            r_id_high;
    t_byte            r_id_mid;

    t_payload         r_gather;
    logic [LANE_W-1:0] r_fill;
    t_byte            r_left;
    logic [SEQ_W-1:0] r_frame;
    logic [SEQ_W-1:0] r_final;

    logic             r_out_valid;
    t_byte            r_out_info;
    t_byte            r_out_seq;
    t_payload         r_out_payload;
    logic             r_out_last;

    logic             proc_go;
    logic             msg_open;
    t_byte            len_eff;
    t_byte            len_m1;
    logic [LANE_W-1:0] lane;
    logic [CNT_W-1:0] n_count;
    t_payload         n_gather;
    t_byte            n_left;
    logic [SEQ_W-1:0] n_final;
    logic [SEQ_W-1:0] frame_base;
    logic             emit;

    assign proc_go     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || proc_go;
    assign i_cfg.ready = 1'b1;

    assign msg_open   = (r_left == 8'd0);
    assign len_eff    = (r_len == 8'd0) ? 8'd1 : r_len;
    assign len_m1     = len_eff - 8'd1;
    assign lane       = msg_open ? '0 : r_fill;
    assign n_count    = CNT_W'(lane) + CNT_W'(1);
    assign n_left     = (msg_open ? len_eff : r_left) - 8'd1;
    assign n_final    = msg_open ? SEQ_W'(len_m1 / FRAME_BYTES) : r_final;
    assign frame_base = msg_open ? '0 : r_frame;
    assign emit       = (n_count == CNT_W'(FRAME_BYTES)) || (n_left == 8'd0);

    always_comb begin
        n_gather = msg_open ? '0 : r_gather;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            if (lane == LANE_W'(k)) begin
                n_gather[8*k +: 8] = r_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.data_byte;
            r_len  <= i_in.msg_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_high <= '0;
            r_id_mid  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ID_HIGH: r_id_high <= i_cfg.data;
                REG_ID_MID:  r_id_mid  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gather <= '0;
            r_fill   <= '0;
            r_left   <= '0;
            r_frame  <= '0;
            r_final  <= '0;
        end else if (proc_go) begin
            r_left  <= n_left;
            r_final <= n_final;
            if (emit) begin
                r_gather <= '0;
                r_fill   <= '0;
                r_frame  <= frame_base + SEQ_W'(1);
            end else begin
                r_gather <= n_gather;
                r_fill   <= LANE_W'(n_count);
                r_frame  <= frame_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (proc_go && emit) || (r_out_valid && !o_out.ready);
        end
        if (proc_go && emit) begin
            r_out_info    <= INFO_EXT_FLAG | 8'(n_count);
            r_out_seq     <= {n_final, frame_base};
            r_out_payload <= n_gather;
            r_out_last    <= (n_left == 8'd0);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.frame_info    = r_out_info;
    assign o_out.id_byte_high  = r_id_high;
    assign o_out.id_byte_mid   = r_id_mid;
    assign o_out.sequence_byte = r_out_seq;
    assign o_out.id_byte_low   = ID_LOW_FIXED;
    assign o_out.payload       = r_out_payload;
    assign o_out.last_frame    = r_out_last;

    a_info_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_info[7] && r_out_info[6:0] != 7'd0
                         && r_out_info[6:0] <= 7'(FRAME_BYTES)))
        else $error("frame byte count out of range");

    a_full_unless_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_out_info[6:0] == 7'(FRAME_BYTES)))
        else $error("partial frame not marked last");

    a_last_closes_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_left == 8'd0))
        else $error("last frame held while message still open");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_out_valid))
        else $error("input stalled without a held frame");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_go && emit && n_left == 8'd0) |=> (r_fill == '0 && r_gather == '0))
        else $error("gather state not cleared after last frame");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for can_message_segmenter: random message streams with
// random idling on both sides, checked frame by frame. Depends on cms_pkg, cms_if.
`timescale 1ns / 1ps

module tb;
    import cms_pkg::*;

    localparam int         WATCHDOG_LIMIT   = 4000;
    localparam int         RANDOM_PHASES    = 8;
    localparam int         PHASE_ITEMS      = 195;
    localparam int         DRAIN_CYCLES     = 8;
    localparam t_cfg_index REG_UNUSED_FIRST = t_cfg_index'(REG_ID_MID + 1);
    localparam t_cfg_index REG_UNUSED_LAST  = '1;

    typedef struct packed {
        t_byte data_byte;
        t_byte msg_length;
    } t_byte_req;

    typedef struct {
        t_byte    frame_info;
        t_byte    id_byte_high;
        t_byte    id_byte_mid;
        t_byte    sequence_byte;
        t_byte    id_byte_low;
        t_payload payload;
        logic     last_frame;
    } t_frame;

    logic i_clk;
    logic i_rst_n;

    cms_in_if  byte_if ();
    cms_out_if frame_if ();
    cms_cfg_if reg_if ();

    can_message_segmenter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (frame_if),
        .i_cfg   (reg_if)
    );

    t_byte_req byte_queue[$];
    t_frame    frames_due[$];
    t_byte_req next_byte;
    int        fault_count  = 0;
    int        quiet_cycles = 0;
    int        send_gap     = 0;
    int        recv_stall   = 0;
    int        stall_draw;
    logic      send_steady  = 1'b0;
    logic      recv_steady  = 1'b0;

    // Segmenter state as the bench sees it
    t_payload   gather_word  = '0;
    logic [3:0] gather_fill  = '0;
    t_byte      bytes_owed   = '0;
    logic [4:0] frame_idx    = '0;
    logic [4:0] last_idx     = '0;
    t_byte      id_high_copy = '0;
    t_byte      id_mid_copy  = '0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int draw_wait(logic steady);
        return steady ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) return 0;
        if (roll < 10) return 255;
        if (roll < 25) return $urandom_range(1, 255);
        return $urandom_range(1, 24);
    endfunction

    task automatic predict_byte(t_byte data, t_byte len_field);
        t_byte  eff_len;
        t_frame frame;
        if (bytes_owed == 0) begin
            eff_len     = (len_field == 0) ? 8'd1 : len_field;
            bytes_owed  = eff_len;
            last_idx    = 5'((int'(eff_len) - 1) / FRAME_BYTES);
            frame_idx   = '0;
            gather_word = '0;
            gather_fill = '0;
        end
        gather_word = gather_word | (t_payload'(data) << (8 * gather_fill[2:0]));
        gather_fill = gather_fill + 4'd1;
        bytes_owed  = bytes_owed - 8'd1;
        if (gather_fill >= FRAME_BYTES || bytes_owed == 0) begin
            frame.frame_info    = INFO_EXT_FLAG | t_byte'(gather_fill);
            frame.id_byte_high  = id_high_copy;
            frame.id_byte_mid   = id_mid_copy;
            frame.sequence_byte = {last_idx[3:0], frame_idx[3:0]};
            frame.id_byte_low   = ID_LOW_FIXED;
            frame.payload       = gather_word;
            frame.last_frame    = (bytes_owed == 0);
            frames_due.push_back(frame);
            gather_word = '0;
            gather_fill = '0;
            frame_idx   = frame_idx + 5'd1;
        end
    endtask

    task automatic compare_field(string label, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, label, want, got);
            fault_count++;
        end
    endtask

    task automatic check_frame();
        t_frame want;
        if (frames_due.size() == 0) begin
            $display("%0t: unexpected frame, expected none actual payload %0h",
                     $time, frame_if.payload);
            fault_count++;
            return;
        end
        want = frames_due.pop_front();
        compare_field("frame_info", want.frame_info, frame_if.frame_info);
        compare_field("id_byte_high", want.id_byte_high, frame_if.id_byte_high);
        compare_field("id_byte_mid", want.id_byte_mid, frame_if.id_byte_mid);
        compare_field("sequence_byte", want.sequence_byte, frame_if.sequence_byte);
        compare_field("id_byte_low", want.id_byte_low, frame_if.id_byte_low);
        compare_field("payload", want.payload, frame_if.payload);
        compare_field("last_frame", want.last_frame, frame_if.last_frame);
    endtask

    task automatic push_byte(t_byte data, t_byte len_field);
        t_byte_req req;
        req.data_byte  = data;
        req.msg_length = len_field;
        byte_queue.push_back(req);
    endtask

    task automatic queue_message(t_byte len_field);
        int count;
        count = (len_field == 0) ? 1 : int'(len_field);
        for (int i = 0; i < count; i++)
            push_byte(t_byte'($urandom), (i == 0) ? len_field : t_byte'($urandom));
    endtask

    task automatic write_register(t_cfg_index index, t_byte value);
        @(posedge i_clk);
        reg_if.valid <= 1'b1;
        reg_if.index <= index;
        reg_if.data  <= value;
        do @(posedge i_clk); while (!reg_if.ready);
        reg_if.valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        do @(negedge i_clk);
        while (byte_queue.size() != 0 || byte_if.valid || frames_due.size() != 0);
    endtask

    // Byte sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_if.valid <= 1'b0;
            send_gap <= 0;
        end else if (!byte_if.valid || byte_if.ready) begin
            if (send_gap != 0) begin
                byte_if.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (byte_queue.size() != 0) begin
                next_byte = byte_queue.pop_front();
                byte_if.valid      <= 1'b1;
                byte_if.data_byte  <= next_byte.data_byte;
                byte_if.msg_length <= next_byte.msg_length;
                send_gap <= draw_wait(send_steady);
                if ($urandom_range(0, 39) == 0) send_steady <= !send_steady;
            end else begin
                byte_if.valid <= 1'b0;
            end
        end
    end

    // Accepted requests and register writes feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && byte_if.valid && byte_if.ready)
            predict_byte(byte_if.data_byte, byte_if.msg_length);
        if (i_rst_n && reg_if.valid && reg_if.ready) begin
            case (reg_if.index)
                REG_ID_HIGH: id_high_copy = reg_if.data;
                REG_ID_MID:  id_mid_copy  = reg_if.data;
                default: ;
            endcase
        end
    end

    // Frame receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_if.ready <= 1'b0;
            recv_stall <= 0;
        end else if (frame_if.valid && frame_if.ready) begin
            check_frame();
            stall_draw = draw_wait(recv_steady);
            if ($urandom_range(0, 39) == 0) recv_steady <= !recv_steady;
            frame_if.ready <= (stall_draw == 0);
            recv_stall <= stall_draw;
        end else if (!frame_if.ready) begin
            if (recv_stall <= 1) frame_if.ready <= 1'b1;
            else recv_stall <= recv_stall - 1;
        end
    end

    always @(posedge i_clk) begin
        if ((byte_if.valid && byte_if.ready) || (frame_if.valid && frame_if.ready)
                || (reg_if.valid && reg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int phase_items;
        int msg_len;
        byte_if.valid      = 1'b0;
        byte_if.data_byte  = '0;
        byte_if.msg_length = '0;
        reg_if.valid       = 1'b0;
        reg_if.index       = '0;
        reg_if.data        = '0;
        frame_if.ready     = 1'b0;
        i_rst_n            = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Single byte, zero length, one full frame, full frame plus one byte,
        // longest message
        push_byte(8'hFF, 8'd1);
        push_byte(8'h00, 8'd0);
        queue_message(8'd8);
        queue_message(8'd9);
        queue_message(8'd255);

        for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
            wait_for_drain();
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            case (phase)
                1: begin
                    write_register(REG_ID_HIGH, 8'hFF);
                    write_register(REG_ID_MID, 8'hFF);
                    write_register(REG_UNUSED_FIRST, t_byte'($urandom));
                    write_register(REG_UNUSED_LAST, t_byte'($urandom));
                end
                2: begin
                    write_register(REG_ID_HIGH, 8'h00);
                    write_register(REG_ID_MID, 8'hFF);
                end
                3: begin
                    write_register(REG_ID_HIGH, 8'hFF);
                    write_register(REG_ID_MID, 8'h00);
                end
                default: begin
                    write_register(REG_ID_HIGH, t_byte'($urandom));
                    write_register(REG_ID_MID, t_byte'($urandom));
                end
            endcase
            @(negedge i_clk);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                msg_len = pick_length();
                if (msg_len > PHASE_ITEMS - phase_items)
                    msg_len = PHASE_ITEMS - phase_items;
                queue_message(t_byte'(msg_len));
                phase_items += (msg_len == 0) ? 1 : msg_len;
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/cms_pkg.sv
design/cms_if.sv
design/can_message_segmenter.sv
bench/tb.sv
